// ===== hdl/wsd_pkg.sv =====
// Shared types and constants for the WebSocket frame deframer and unmasker.
package wsd_pkg;

	localparam int LEN_W           = 63;
	localparam int LENGTH_BITS_DEF = 63;

	localparam logic [3:0] OP_CONT  = 4'h0;
	localparam logic [3:0] OP_TEXT  = 4'h1;
	localparam logic [3:0] OP_BIN   = 4'h2;
	localparam logic [3:0] OP_CLOSE = 4'h8;
	localparam logic [3:0] OP_PING  = 4'h9;
	localparam logic [3:0] OP_PONG  = 4'hA;

	localparam logic [6:0] LEN_CODE_16 = 7'd126;
	localparam logic [6:0] LEN_CODE_64 = 7'd127;

	typedef enum logic [4:0] {
		PH_HDR0    = 5'b00001,
		PH_HDR1    = 5'b00010,
		PH_EXTLEN  = 5'b00100,
		PH_MASK    = 5'b01000,
		PH_PAYLOAD = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [7:0] rx_byte;
	} in_t;

	typedef struct packed {
		logic [7:0]       payload_byte;
		logic             payload_valid;
		logic [3:0]       frame_opcode;
		logic             frame_fin;
		logic             header_done;
		logic [LEN_W-1:0] frame_length;
		logic             frame_last;
		logic             protocol_error;
	} out_t;

endpackage

// ===== hdl/wsd_stream_if.sv =====
// Valid/ready stream channel carrying one request payload.
interface wsd_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/websocket_frame_deframer_unmask_core.sv =====
// WebSocket frame header parser and payload unmasker, one byte per request.
// Each accepted byte's result is registered in the output register (or skid when stalled).
// Throughput: one byte per cycle while the skid entry is empty; the header and payload
// logic sits between the parser state registers and a two-entry output register/skid pair.
// Reset: arst_n clears the parser to the first header byte, all counters, key,
// held opcode/FIN and the sticky error; output and skid valids are cleared.
module websocket_frame_deframer_unmask_core #(
	parameter int LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	wsd_stream_if.sink          rx,
	wsd_stream_if.source        tx
);
	import wsd_pkg::*;

	localparam int LB = LENGTH_BITS;

	phase_t          phase_q, phase_n;
	logic            long64_q, long64_n;
	logic [2:0]      cnt_q, cnt_n;
	logic [LB-1:0]   acc_q, acc_n;
	logic            ovf_q, ovf_n;
	logic [LB-1:0]   remain_q, remain_n;
	logic [31:0]     key_q, key_n;
	logic [1:0]      key_idx_q, key_idx_n;
	logic [3:0]      opcode_q, opcode_n;
	logic            fin_q, fin_n;
	logic            masked_q, masked_n;
	logic            err_q, err_n;

	out_t            res;
	out_t            out_q, skid_q;
	logic            out_v_q, skid_v_q;
	logic            acc_req;

	logic [7:0]      b;
	logic [3:0]      op;
	logic            known;
	logic [LB-1:0]   len_v;
	logic            hdr_done;
	logic            last;
	logic [7:0]      pay;
	logic            pay_v;
	logic [LB-1:0]   acc_shift;
	logic            ovf_v;
	logic            need_last;
	logic [7:0]      key_byte;

	assign rx.ready = !skid_v_q;
	assign acc_req  = rx.valid && rx.ready;
	assign b        = rx.payload.rx_byte;
	assign op       = b[3:0];
	assign acc_shift = {acc_q[LB-9:0], b};
	assign ovf_v     = ovf_q | (|acc_q[LB-1 -: 8]);
	assign key_byte  = key_q[{~key_idx_q, 3'b000} +: 8];

	always_comb begin
		phase_n   = phase_q;
		long64_n  = long64_q;
		cnt_n     = cnt_q;
		acc_n     = acc_q;
		ovf_n     = ovf_q;
		remain_n  = remain_q;
		key_n     = key_q;
		key_idx_n = key_idx_q;
		opcode_n  = opcode_q;
		fin_n     = fin_q;
		masked_n  = masked_q;
		err_n     = err_q;
		known     = 1'b0;
		len_v     = '0;
		hdr_done  = 1'b0;
		last      = 1'b0;
		pay       = '0;
		pay_v     = 1'b0;
		need_last = 1'b0;

		if (!err_q) begin
			case (phase_q)
				PH_HDR1: begin
					masked_n = b[7];
					cnt_n    = '0;
					if (b[6:0] >= LEN_CODE_16) begin
						long64_n = (b[6:0] == LEN_CODE_64);
						acc_n    = '0;
						ovf_n    = 1'b0;
						phase_n  = PH_EXTLEN;
					end else begin
						known = 1'b1;
						len_v = LB'(b[6:0]);
					end
				end
				PH_EXTLEN: begin
					acc_n     = acc_shift;
					ovf_n     = ovf_v;
					need_last = long64_q ? (cnt_q == 3'd7) : (cnt_q == 3'd1);
					if (need_last) begin
						if (long64_q && ovf_v) begin
							err_n = 1'b1;
						end else begin
							known = 1'b1;
							len_v = acc_shift;
						end
					end else begin
						cnt_n = cnt_q + 3'd1;
					end
				end
				PH_MASK: begin
					key_n = {key_q[23:0], b};
					if (cnt_q == 3'd3) begin
						hdr_done = 1'b1;
						len_v    = remain_q;
					end else begin
						cnt_n = cnt_q + 3'd1;
					end
				end
				PH_PAYLOAD: begin
					pay       = (masked_q && opcode_q != OP_PING) ? (b ^ key_byte) : b;
					pay_v     = 1'b1;
					key_idx_n = key_idx_q + 2'd1;
					remain_n  = remain_q - LB'(1);
					if (remain_n == '0) begin
						last    = 1'b1;
						phase_n = PH_HDR0;
					end
				end
				default: begin
					if ((|b[6:4]) || !(op inside {[OP_CONT:OP_BIN], [OP_CLOSE:OP_PONG]})) begin
						err_n = 1'b1;
					end else begin
						fin_n = b[7];
						if (op != OP_CONT) opcode_n = op;
						phase_n = PH_HDR1;
					end
				end
			endcase

			if (known) begin
				remain_n = len_v;
				cnt_n    = '0;
				if (masked_n) phase_n = PH_MASK;
				else hdr_done = 1'b1;
			end
			if (hdr_done) begin
				key_idx_n = '0;
				if (len_v == '0) begin
					last    = 1'b1;
					phase_n = PH_HDR0;
				end else begin
					phase_n = PH_PAYLOAD;
				end
			end
		end

		res                = '0;
		res.frame_opcode   = opcode_n;
		res.frame_fin      = fin_n;
		res.protocol_error = err_n;
		if (!err_n) begin
			res.payload_byte  = pay;
			res.payload_valid = pay_v;
			res.header_done   = hdr_done;
			res.frame_length  = hdr_done ? LEN_W'(len_v) : '0;
			res.frame_last    = last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HDR0;
			long64_q  <= 1'b0;
			cnt_q     <= '0;
			acc_q     <= '0;
			ovf_q     <= 1'b0;
			remain_q  <= '0;
			key_q     <= '0;
			key_idx_q <= '0;
			opcode_q  <= OP_CONT;
			fin_q     <= 1'b0;
			masked_q  <= 1'b0;
			err_q     <= 1'b0;
		end else if (acc_req) begin
			phase_q   <= phase_n;
			long64_q  <= long64_n;
			cnt_q     <= cnt_n;
			acc_q     <= acc_n;
			ovf_q     <= ovf_n;
			remain_q  <= remain_n;
			key_q     <= key_n;
			key_idx_q <= key_idx_n;
			opcode_q  <= opcode_n;
			fin_q     <= fin_n;
			masked_q  <= masked_n;
			err_q     <= err_n;
		end
	end

	// output register with skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || tx.ready) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= acc_req;
			end
		end else if (acc_req) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || tx.ready) begin
			if (skid_v_q) out_q <= skid_q;
			else if (acc_req) out_q <= res;
		end else if (acc_req) begin
			skid_q <= res;
		end
	end

	assign tx.valid   = out_v_q;
	assign tx.payload = out_q;

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_q |=> err_q)
		else $error("protocol error flag cleared without reset");

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry held while output register empty");

	a_payload_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_req && !err_q && phase_q == PH_PAYLOAD) |-> (res.payload_valid && !res.header_done))
		else $error("payload byte not flagged as payload");

	a_done_resets_key: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_req && res.header_done) |=> (key_idx_q == 2'd0))
		else $error("key index not cleared at end of header");

endmodule
